// ===== sv/dtd_pkg.sv =====
`timescale 1ns / 1ps

package dtd_pkg;

   // one g in raw sample counts; the baseline starts here in Q17.16
   localparam int unsigned ONE_G = 16384;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 17;

   localparam logic [15:0] EMA_ALPHA_RST      = 16'd655;
   localparam logic [15:0] WARMUP_SAMPLES_RST = 16'd201;
   localparam logic [16:0] SPIKE_THR_RST      = 17'd4096;
   localparam logic [16:0] REARM_THR_RST      = 17'd1024;
   localparam logic [15:0] SHOCK_MAX_RST      = 16'd50;
   localparam logic [15:0] GAP_MIN_RST        = 16'd60;
   localparam logic [15:0] GAP_MAX_RST        = 16'd400;
   localparam logic [15:0] REFRACTORY_RST     = 16'd500;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_EMA_ALPHA      = 3'd0,
      REG_WARMUP_SAMPLES = 3'd1,
      REG_SPIKE_THR      = 3'd2,
      REG_REARM_THR      = 3'd3,
      REG_SHOCK_MAX      = 3'd4,
      REG_GAP_MIN        = 3'd5,
      REG_GAP_MAX        = 3'd6,
      REG_REFRACTORY     = 3'd7
   } csr_reg_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SHOCK = 2'd1,
      PH_GAP   = 2'd2,
      PH_REFR  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SQUARE,
      SEQ_ROOT,
      SEQ_DIFF,
      SEQ_SCALE,
      SEQ_UPDATE,
      SEQ_DECIDE
   } seq_state_type;

   // milliseconds to microseconds: ms * (1024 - 16 - 8)
   function automatic logic [26:0] ms_to_us(input logic [16:0] ms);
      logic [26:0] w;
      w = {10'b0, ms};
      return (w << 10) - (w << 4) - (w << 3);
   endfunction

   function automatic logic [15:0] abs16(input logic signed [15:0] a);
      logic [16:0] neg;
      neg = 17'd0 - {a[15], a};
      return a[15] ? neg[15:0] : a[15:0];
   endfunction

endpackage

// ===== sv/dtd_isqrt.sv =====
`timescale 1ns / 1ps

// Floor square root of a 32-bit word, two radicand bits per cycle.
module dtd_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] radicand,
   output logic        done,
   output logic [15:0] root
);

   logic [31:0] rad_ff;
   logic [17:0] rem_ff;
   logic [15:0] root_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [19:0] shifted;
   logic [19:0] trial;
   logic        take;
   logic [17:0] rem_in;
   logic [15:0] root_in;
   logic        last;

   always_comb begin
      shifted = {rem_ff, rad_ff[31:30]};
      trial   = {2'b00, root_ff, 2'b01};
      take    = shifted >= trial;
      rem_in  = take ? 18'(shifted - trial) : shifted[17:0];
      root_in = {root_ff[14:0], take};
      last    = busy_ff && (cnt_ff == 4'hF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         cnt_ff  <= cnt_ff + 4'd1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

   // a new radicand must never land on a root still in progress
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("root unit restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("root done without a preceding busy cycle");

endmodule

// ===== sv/double_tap_detector.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    time_us, acc_x, acc_y, acc_z
// rsp       out        rsp_valid/stall    double_tap (one word per req word)
// csr       in         csr_we             csr_index, csr_wdata
//
// A word passes from acceptance to result through the shared 16x16 squarer,
// the two-bit-per-cycle root unit, a capture step, and the baseline update
// and tap decision (DIFF, SCALE, UPDATE, DECIDE). The next word is taken once
// the result has moved to the output register, so words never overlap.
// Synchronous active-high reset loads the register defaults and the idle state.
// A stalled result holds the decision step until the output register frees.
module double_tap_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_time_us,
   input  logic signed [15:0]              req_acc_x,
   input  logic signed [15:0]              req_acc_y,
   input  logic signed [15:0]              req_acc_z,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_double_tap,
   input  logic                            csr_we,
   input  logic [dtd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dtd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // configuration
   logic [15:0] alpha_ff;
   logic [16:0] spike_thr_ff;
   logic [16:0] rearm_thr_ff;
   logic [15:0] shock_max_ff;
   logic [15:0] gap_min_ff;
   logic [15:0] gap_max_ff;
   logic [15:0] refr_ff;

   // sequencer and datapath
   dtd_pkg::seq_state_type seq_ff, seq_in;
   logic [1:0]          sq_cnt_ff;
   logic [31:0]         time_ff;
   logic signed [15:0]  ax_ff, ay_ff, az_ff;
   logic [15:0]         sel_mag;
   logic [31:0]         square;
   logic [31:0]         prod_ff;
   logic [31:0]         acc_ff;
   logic [15:0]         mag_ff;
   logic                diff_neg_ff;
   logic [32:0]         diff_ff;
   logic [48:0]         scaled;
   logic [32:0]         step_ff;
   logic [32:0]         base_ff;
   logic [32:0]         m_q;

   // detector state
   dtd_pkg::phase_type  phase_ff, phase_in;
   logic [31:0]         mark_ff, mark_in;
   logic [15:0]         warm_left_ff, warm_left_in;
   logic                primed_ff, primed_in;

   logic                accept;
   logic                sq_start;
   logic                sq_done;
   logic [15:0]         sq_root;
   logic                dec_fire;
   logic                tap_in;
   logic                run;
   logic [32:0]         dev;
   logic                spike, quiet;
   logic [31:0]         el_us;
   logic                shock_over, gap_ge_min, gap_over, refr_over;

   logic                rsp_valid_ff;
   logic                rsp_tap_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (seq_ff != dtd_pkg::SEQ_IDLE);
   assign m_q       = {1'b0, mag_ff, 16'b0};

   // ---------------- configuration port ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= dtd_pkg::EMA_ALPHA_RST;
         spike_thr_ff <= dtd_pkg::SPIKE_THR_RST;
         rearm_thr_ff <= dtd_pkg::REARM_THR_RST;
         shock_max_ff <= dtd_pkg::SHOCK_MAX_RST;
         gap_min_ff   <= dtd_pkg::GAP_MIN_RST;
         gap_max_ff   <= dtd_pkg::GAP_MAX_RST;
         refr_ff      <= dtd_pkg::REFRACTORY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            dtd_pkg::REG_EMA_ALPHA:      alpha_ff     <= csr_wdata[15:0];
            dtd_pkg::REG_WARMUP_SAMPLES: ;
            dtd_pkg::REG_SPIKE_THR:      spike_thr_ff <= csr_wdata;
            dtd_pkg::REG_REARM_THR:      rearm_thr_ff <= csr_wdata;
            dtd_pkg::REG_SHOCK_MAX:      shock_max_ff <= csr_wdata[15:0];
            dtd_pkg::REG_GAP_MIN:        gap_min_ff   <= csr_wdata[15:0];
            dtd_pkg::REG_GAP_MAX:        gap_max_ff   <= csr_wdata[15:0];
            dtd_pkg::REG_REFRACTORY:     refr_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------- squarer ----------------
   always_comb begin
      unique case (sq_cnt_ff)
         2'd0:    sel_mag = dtd_pkg::abs16(ax_ff);
         2'd1:    sel_mag = dtd_pkg::abs16(ay_ff);
         2'd2:    sel_mag = dtd_pkg::abs16(az_ff);
         default: sel_mag = '0;
      endcase
      square = 32'(sel_mag) * 32'(sel_mag);
   end

   assign sq_start = (seq_ff == dtd_pkg::SEQ_SQUARE) && (sq_cnt_ff == 2'd3);

   dtd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_ff + prod_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign scaled = diff_ff * alpha_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         time_ff   <= req_time_us;
         ax_ff     <= req_acc_x;
         ay_ff     <= req_acc_y;
         az_ff     <= req_acc_z;
         sq_cnt_ff <= 2'd0;
      end
      if (seq_ff == dtd_pkg::SEQ_SQUARE) begin
         prod_ff   <= square;
         acc_ff    <= (sq_cnt_ff == 2'd0) ? 32'd0 : acc_ff + prod_ff;
         sq_cnt_ff <= sq_cnt_ff + 2'd1;
      end
      if (seq_ff == dtd_pkg::SEQ_ROOT && sq_done) begin
         mag_ff <= sq_root;
      end
      if (seq_ff == dtd_pkg::SEQ_DIFF) begin
         diff_neg_ff <= m_q < base_ff;
         diff_ff     <= (m_q < base_ff) ? base_ff - m_q : m_q - base_ff;
      end
      if (seq_ff == dtd_pkg::SEQ_SCALE) begin
         step_ff <= scaled[48:16];
      end
   end

   // ---------------- decision ----------------
   always_comb begin
      dev   = (m_q >= base_ff) ? m_q - base_ff : base_ff - m_q;
      spike = dev > {spike_thr_ff, 16'b0};
      quiet = dev < {rearm_thr_ff, 16'b0};

      // elapsed_ms > K  is  elapsed_us >= (K + 1) * 1000
      el_us      = time_ff - mark_ff;
      shock_over = el_us >= 32'(dtd_pkg::ms_to_us({1'b0, shock_max_ff} + 17'd1));
      gap_ge_min = el_us >= 32'(dtd_pkg::ms_to_us({1'b0, gap_min_ff}));
      gap_over   = el_us >= 32'(dtd_pkg::ms_to_us({1'b0, gap_max_ff} + 17'd1));
      refr_over  = el_us >= 32'(dtd_pkg::ms_to_us({1'b0, refr_ff} + 17'd1));
   end

   always_comb begin
      seq_in       = seq_ff;
      phase_in     = phase_ff;
      mark_in      = mark_ff;
      warm_left_in = warm_left_ff;
      primed_in    = primed_ff;
      tap_in       = 1'b0;
      dec_fire     = 1'b0;
      run          = primed_ff || (warm_left_ff == 16'd0);

      unique case (seq_ff)
         dtd_pkg::SEQ_IDLE:   if (accept) seq_in = dtd_pkg::SEQ_SQUARE;
         dtd_pkg::SEQ_SQUARE: if (sq_start) seq_in = dtd_pkg::SEQ_ROOT;
         dtd_pkg::SEQ_ROOT:   if (sq_done) seq_in = dtd_pkg::SEQ_DIFF;
         dtd_pkg::SEQ_DIFF:   seq_in = dtd_pkg::SEQ_SCALE;
         dtd_pkg::SEQ_SCALE:  seq_in = dtd_pkg::SEQ_UPDATE;
         dtd_pkg::SEQ_UPDATE: seq_in = dtd_pkg::SEQ_DECIDE;
         dtd_pkg::SEQ_DECIDE: begin
            // hold until the output register can take the word
            dec_fire = !rsp_valid_ff || !rsp_stall;
            if (dec_fire) begin
               seq_in = dtd_pkg::SEQ_IDLE;
               if (!primed_ff) begin
                  if (warm_left_ff != 16'd0) begin
                     warm_left_in = warm_left_ff - 16'd1;
                  end else begin
                     primed_in = 1'b1;
                  end
               end
               if (run) begin
                  unique case (phase_ff)
                     dtd_pkg::PH_IDLE: begin
                        if (spike) begin
                           phase_in = dtd_pkg::PH_SHOCK;
                           mark_in  = time_ff;
                        end
                     end
                     dtd_pkg::PH_SHOCK: begin
                        if (quiet) begin
                           phase_in = dtd_pkg::PH_GAP;
                           mark_in  = time_ff;
                        end else if (shock_over) begin
                           phase_in = dtd_pkg::PH_IDLE;
                        end
                     end
                     dtd_pkg::PH_GAP: begin
                        if (spike) begin
                           mark_in = time_ff;
                           if (gap_ge_min && !gap_over) begin
                              tap_in   = 1'b1;
                              phase_in = dtd_pkg::PH_REFR;
                           end else begin
                              // ringing or a late spike: restart from the shock
                              phase_in = dtd_pkg::PH_SHOCK;
                           end
                        end else if (gap_over) begin
                           phase_in = dtd_pkg::PH_IDLE;
                        end
                     end
                     dtd_pkg::PH_REFR: begin
                        if (refr_over) phase_in = dtd_pkg::PH_IDLE;
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: seq_in = dtd_pkg::SEQ_IDLE;
      endcase

      if (csr_we && csr_index == dtd_pkg::REG_WARMUP_SAMPLES) begin
         warm_left_in = csr_wdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= dtd_pkg::SEQ_IDLE;
         phase_ff     <= dtd_pkg::PH_IDLE;
         mark_ff      <= '0;
         base_ff      <= 33'(dtd_pkg::ONE_G) << 16;
         warm_left_ff <= dtd_pkg::WARMUP_SAMPLES_RST;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         mark_ff      <= mark_in;
         warm_left_ff <= warm_left_in;
         primed_ff    <= primed_in;
         if (seq_ff == dtd_pkg::SEQ_UPDATE) begin
            base_ff <= diff_neg_ff ? base_ff - step_ff : base_ff + step_ff;
         end
         if (dec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dec_fire) rsp_tap_ff <= tap_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_double_tap = rsp_tap_ff;

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(seq_ff) == dtd_pkg::SEQ_DECIDE)
      else $error("result raised outside the decision step");

   a_root_in_wait: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> seq_ff == dtd_pkg::SEQ_ROOT)
      else $error("root finished while sequencer was not waiting");

   a_tap_to_refr: assert property (@(posedge clock) disable iff (reset)
      (dec_fire && tap_in) |=> phase_ff == dtd_pkg::PH_REFR)
      else $error("double tap without entering refractory");

   a_no_tap_in_warmup: assert property (@(posedge clock) disable iff (reset)
      (dec_fire && !primed_ff && warm_left_ff != 16'd0) |-> !tap_in)
      else $error("double tap reported during warmup");

endmodule
